FILE: src/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled during reset.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: implication");
// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");
`else
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

FILE: src/mrbft_pkg.sv
// ----------------------------------------------------------------------------
// Model rail bus transceiver package
// Beat types, bus constants, codes and controller/datapath interface structs.
// ----------------------------------------------------------------------------
package mrbft_pkg;

  // Bus geometry.
  localparam int FrameBits     = 1536;
  localparam int BaseFrameBits = 96;
  localparam int HuntMinBits   = 192;
  localparam int HuntLastIdx   = 190;
  localparam int ChanBits      = 12;

  localparam logic [11:0] SyncMask    = 12'hFEF;
  localparam logic [11:0] SyncZero    = 12'h928;
  localparam logic [11:0] PayloadMask = 12'h6DB;

  // Function codes.
  localparam logic [2:0] FuncRise  = 3'd0;
  localparam logic [2:0] FuncFall  = 3'd1;
  localparam logic [2:0] FuncRead  = 3'd2;
  localparam logic [2:0] FuncWrite = 3'd3;
  localparam logic [2:0] FuncTick  = 3'd4;
  localparam logic [2:0] FuncDrop  = 3'd5;

  // Sync phase codes.
  localparam logic [2:0] PhHunt  = 3'd0;
  localparam logic [2:0] PhWait1 = 3'd1;
  localparam logic [2:0] PhFind  = 3'd2;
  localparam logic [2:0] PhWait2 = 3'd3;
  localparam logic [2:0] PhSync  = 3'd4;

  typedef struct packed {
    logic [2:0] func;
    logic       data_bit;
    logic [6:0] channel;
    logic [7:0] channel_value;
  } in_beat_t;

  typedef struct packed {
    logic       drive_enable;
    logic       drive_value;
    logic [7:0] channel_data;
    logic [2:0] sync_phase_out;
  } out_beat_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       load_item;
    logic       idx_clr;
    logic       idx_inc;
    logic       clr_wr;
    logic       rise_upd;
    logic       rise_wr;
    logic       fall_wr;
    logic       base_ch;
    logic       base_zero;
    logic       base_next;
    logic       rd_take;
    logic       wr_chan;
    logic       hunt_take;
    logic       hunt_apply;
    logic       find_apply;
    logic       phase_set;
    logic [2:0] phase_val;
    logic       drop;
    logic       out_load;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [2:0] func;
    logic [2:0] phase;
    logic       rise_byte;
    logic       bc_in_frame;
    logic       bc_ge_hunt;
    logic       frame_passed;
    logic       mark_bit;
    logic       idx_last_clear;
    logic       idx_last_byte;
    logic       idx_last_chan;
    logic       idx_last_hunt;
    logic       hunt_zero3;
    logic       hunt_ok;
    logic       sync_match;
    logic       base_last;
  } ctrl_sts_t;

  // First bit position of a channel in the frame.
  function automatic logic [10:0] channel_start(input logic [6:0] ch);
    logic [10:0] a;
    logic [10:0] b;
    a = {7'd0, 4'd15 - ch[3:0]} * 11'd96;
    b = {8'd0, 3'd7 - ch[6:4]} * 11'd12;
    return a + b;
  endfunction

  // Spread a payload byte over twelve wire bits with padding ones.
  function automatic logic [11:0] expand_byte(input logic [7:0] v);
    return {1'b1, v[7:6], 1'b1, v[5:4], 1'b1, v[3:2], 1'b1, v[1:0]};
  endfunction

  // Collect the payload bits back out of twelve wire bits.
  function automatic logic [7:0] collapse_word(input logic [11:0] w);
    return {w[10:9], w[7:6], w[4:3], w[1:0]};
  endfunction

endpackage

FILE: src/mrbft_datapath.sv
// ----------------------------------------------------------------------------
// Model rail bus transceiver datapath
// Frame stores, bit counter, sync registers and the result register.
// ----------------------------------------------------------------------------
module mrbft_datapath (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  mrbft_pkg::in_beat_t  in_data_i,
  input  mrbft_pkg::ctrl_cmd_t cmd_i,
  output mrbft_pkg::ctrl_sts_t sts_o,
  output mrbft_pkg::out_beat_t out_data_o
);
  import mrbft_pkg::*;

  // Bit-wide frame stores.
  logic rx_mem [FrameBits];
  logic mk_mem [FrameBits];
  logic db_mem [FrameBits];

  logic rx_rdata_q, mk_rdata_q, db_rdata_q;

  in_beat_t    item_q;
  logic [10:0] bc_q, bc_d;
  logic [7:0]  gen_q, gen_d;
  logic [2:0]  phase_q, phase_d;
  logic [10:0] mark_bc_q, mark_bc_d;
  logic [7:0]  mark_gen_q, mark_gen_d;
  logic [7:0]  partial_q;
  logic [10:0] idx_q;
  logic [10:0] base_q;
  logic [11:0] w_q;
  logic [1:0]  run_q;
  logic        en_q, dv_q;
  out_beat_t   out_q, out_d;

  logic [11:0] bcp1;
  logic [10:0] addr;
  logic [10:0] hunt_i;
  logic [7:0]  gen_diff;
  logic [11:0] wexp;
  logic [11:0] find_sum;

  logic        rx_we, rx_wdata;
  logic [10:0] rx_waddr;
  logic        mk_we, mk_wdata;
  logic [10:0] mk_waddr;

  assign bcp1     = {1'b0, bc_q} + 12'd1;
  assign addr     = base_q + idx_q;
  assign hunt_i   = idx_q - 11'd2;
  assign gen_diff = gen_q - mark_gen_q;
  assign wexp     = expand_byte(item_q.channel_value);
  assign find_sum = {1'b0, bc_q} + 12'(FrameBits) - {1'b0, base_q};

  // Store write port steering.
  always_comb begin
    rx_we    = cmd_i.clr_wr | cmd_i.rise_wr;
    rx_waddr = cmd_i.clr_wr ? idx_q : addr;
    rx_wdata = cmd_i.clr_wr ? 1'b1 : partial_q[idx_q[2:0]];
    mk_we    = cmd_i.clr_wr | cmd_i.fall_wr | (cmd_i.wr_chan & PayloadMask[idx_q[3:0]]);
    mk_wdata = cmd_i.wr_chan;
    if (cmd_i.clr_wr) begin
      mk_waddr = idx_q;
    end else if (cmd_i.fall_wr) begin
      mk_waddr = bc_q;
    end else begin
      mk_waddr = addr;
    end
  end

  // Receive store.
  always_ff @(posedge clk_i) begin
    if (rx_we) begin
      rx_mem[rx_waddr] <= rx_wdata;
    end
    rx_rdata_q <= rx_mem[addr];
  end

  // Drive mark store.
  always_ff @(posedge clk_i) begin
    if (mk_we) begin
      mk_mem[mk_waddr] <= mk_wdata;
    end
    mk_rdata_q <= mk_mem[bc_q];
  end

  // Drive bit store.
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_chan) begin
      db_mem[addr] <= wexp[idx_q[3:0]];
    end
    db_rdata_q <= db_mem[bc_q];
  end

  // Counter, generation, phase and wait mark updates.
  always_comb begin
    bc_d       = bc_q;
    gen_d      = gen_q;
    phase_d    = phase_q;
    mark_bc_d  = mark_bc_q;
    mark_gen_d = mark_gen_q;
    if (cmd_i.rise_upd) begin
      if (bcp1 >= 12'(FrameBits)) begin
        bc_d  = '0;
        gen_d = gen_q + 8'd1;
      end else begin
        bc_d = bcp1[10:0];
      end
    end
    if (cmd_i.hunt_apply) begin
      bc_d       = bc_q - hunt_i;
      mark_bc_d  = bc_q - hunt_i;
      mark_gen_d = gen_q;
      phase_d    = PhWait1;
    end
    if (cmd_i.find_apply) begin
      bc_d       = (bc_q >= base_q) ? (bc_q - base_q) : find_sum[10:0];
      mark_bc_d  = (bc_q >= base_q) ? (bc_q - base_q) : find_sum[10:0];
      mark_gen_d = gen_q;
      phase_d    = PhWait2;
    end
    if (cmd_i.phase_set) begin
      phase_d = cmd_i.phase_val;
    end
    if (cmd_i.drop) begin
      bc_d    = '0;
      gen_d   = '0;
      phase_d = PhHunt;
    end
  end

  // Control state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bc_q       <= '0;
      gen_q      <= '0;
      phase_q    <= PhHunt;
      mark_bc_q  <= '0;
      mark_gen_q <= '0;
      partial_q  <= '0;
      idx_q      <= '0;
    end else begin
      bc_q       <= bc_d;
      gen_q      <= gen_d;
      phase_q    <= phase_d;
      mark_bc_q  <= mark_bc_d;
      mark_gen_q <= mark_gen_d;
      if (cmd_i.rise_upd) begin
        partial_q <= {item_q.data_bit, partial_q[7:1]};
      end
      if (cmd_i.idx_clr) begin
        idx_q <= '0;
      end else if (cmd_i.idx_inc) begin
        idx_q <= idx_q + 11'd1;
      end
    end
  end

  // Item, base pointer, word and result payload registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      item_q <= in_data_i;
      en_q   <= 1'b0;
      dv_q   <= 1'b0;
    end
    if (cmd_i.fall_wr) begin
      en_q <= 1'b1;
      dv_q <= db_rdata_q;
    end
    if (cmd_i.base_ch) begin
      base_q <= channel_start(item_q.channel);
    end else if (cmd_i.base_zero) begin
      base_q <= '0;
    end else if (cmd_i.base_next) begin
      base_q <= base_q + 11'(BaseFrameBits);
    end else if (cmd_i.rise_upd) begin
      base_q <= bcp1[10:0] - 11'd8;
    end
    if (cmd_i.rd_take) begin
      w_q[idx_q[3:0]] <= rx_rdata_q;
    end
    if (cmd_i.hunt_take) begin
      run_q <= {run_q[0], rx_rdata_q};
    end
    if (cmd_i.out_load) begin
      out_q <= out_d;
    end
  end

  // Result beat assembly.
  always_comb begin
    out_d.drive_enable   = en_q;
    out_d.drive_value    = dv_q;
    out_d.channel_data   = (item_q.func == FuncRead) ? collapse_word(w_q) : 8'd0;
    out_d.sync_phase_out = phase_q;
  end

  assign out_data_o = out_q;

  // Status toward the controller.
  always_comb begin
    sts_o.func           = item_q.func;
    sts_o.phase          = phase_q;
    sts_o.rise_byte      = (bcp1[2:0] == 3'd0) && (bcp1 <= 12'(FrameBits));
    sts_o.bc_in_frame    = bc_q < 11'(FrameBits);
    sts_o.bc_ge_hunt     = bc_q >= 11'(HuntMinBits);
    sts_o.frame_passed   = (gen_diff >= 8'd2) || ((gen_diff == 8'd1) && (bc_q >= mark_bc_q));
    sts_o.mark_bit       = mk_rdata_q;
    sts_o.idx_last_clear = idx_q == 11'(FrameBits - 1);
    sts_o.idx_last_byte  = idx_q == 11'd7;
    sts_o.idx_last_chan  = idx_q == 11'(ChanBits - 1);
    sts_o.idx_last_hunt  = idx_q == 11'(HuntLastIdx);
    sts_o.hunt_zero3     = (idx_q >= 11'd2) && !rx_rdata_q && (run_q == 2'b00);
    sts_o.hunt_ok        = bc_q > hunt_i;
    sts_o.sync_match     = (w_q & SyncMask) == SyncZero;
    sts_o.base_last      = base_q == 11'(FrameBits - BaseFrameBits);
  end

endmodule

FILE: src/mrbft_ctrl.sv
// ----------------------------------------------------------------------------
// Model rail bus transceiver controller
// Sequences each function over the datapath and owns the handshakes.
// ----------------------------------------------------------------------------
module mrbft_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  input  mrbft_pkg::ctrl_sts_t sts_i,
  output mrbft_pkg::ctrl_cmd_t cmd_o
);
  import mrbft_pkg::*;

  localparam logic [3:0] SClear   = 4'd0;
  localparam logic [3:0] SIdle    = 4'd1;
  localparam logic [3:0] SExec    = 4'd2;
  localparam logic [3:0] SRiseWr  = 4'd3;
  localparam logic [3:0] SFallChk = 4'd4;
  localparam logic [3:0] SRdAdr   = 4'd5;
  localparam logic [3:0] SRdDat   = 4'd6;
  localparam logic [3:0] SRdEval  = 4'd7;
  localparam logic [3:0] SWrChan  = 4'd8;
  localparam logic [3:0] SHuntAdr = 4'd9;
  localparam logic [3:0] SHuntDat = 4'd10;
  localparam logic [3:0] SDone    = 4'd11;

  logic [3:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;

  assign in_stall_o  = state_q != SIdle;
  assign out_valid_o = out_valid_q;

  // Next state and command decode.
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      SClear: begin
        cmd_o.clr_wr  = 1'b1;
        cmd_o.idx_inc = 1'b1;
        if (sts_i.idx_last_clear) begin
          cmd_o.idx_clr = 1'b1;
          state_d       = SIdle;
        end
      end
      SIdle: begin
        if (in_valid_i) begin
          cmd_o.load_item = 1'b1;
          cmd_o.idx_clr   = 1'b1;
          state_d         = SExec;
        end
      end
      SExec: begin
        state_d = SDone;
        case (sts_i.func)
          FuncRise: begin
            cmd_o.rise_upd = 1'b1;
            if (sts_i.rise_byte) begin
              state_d = SRiseWr;
            end
          end
          FuncFall: state_d = SFallChk;
          FuncRead: begin
            cmd_o.base_ch = 1'b1;
            state_d       = SRdAdr;
          end
          FuncWrite: begin
            cmd_o.base_ch = 1'b1;
            state_d       = SWrChan;
          end
          FuncTick: begin
            case (sts_i.phase)
              PhHunt: begin
                if (sts_i.bc_ge_hunt) begin
                  cmd_o.base_zero = 1'b1;
                  state_d         = SHuntAdr;
                end
              end
              PhWait1: begin
                cmd_o.phase_set = sts_i.frame_passed;
                cmd_o.phase_val = PhFind;
              end
              PhWait2: begin
                cmd_o.phase_set = sts_i.frame_passed;
                cmd_o.phase_val = PhSync;
              end
              PhFind, PhSync: begin
                cmd_o.base_zero = 1'b1;
                state_d         = SRdAdr;
              end
              default: begin
                cmd_o.phase_set = 1'b1;
                cmd_o.phase_val = PhHunt;
              end
            endcase
          end
          FuncDrop: cmd_o.drop = 1'b1;
          default: state_d = SDone;
        endcase
      end
      SRiseWr: begin
        cmd_o.rise_wr = 1'b1;
        cmd_o.idx_inc = 1'b1;
        if (sts_i.idx_last_byte) begin
          state_d = SDone;
        end
      end
      SFallChk: begin
        cmd_o.fall_wr = sts_i.bc_in_frame && sts_i.mark_bit;
        state_d       = SDone;
      end
      SRdAdr: state_d = SRdDat;
      SRdDat: begin
        cmd_o.rd_take = 1'b1;
        if (sts_i.idx_last_chan) begin
          cmd_o.idx_clr = 1'b1;
          state_d       = SRdEval;
        end else begin
          cmd_o.idx_inc = 1'b1;
          state_d       = SRdAdr;
        end
      end
      SRdEval: begin
        state_d = SDone;
        if (sts_i.func == FuncTick) begin
          if (sts_i.phase == PhSync) begin
            cmd_o.phase_set = !sts_i.sync_match;
            cmd_o.phase_val = PhHunt;
          end else if (sts_i.sync_match) begin
            cmd_o.find_apply = 1'b1;
          end else if (sts_i.base_last) begin
            cmd_o.phase_set = 1'b1;
            cmd_o.phase_val = PhHunt;
          end else begin
            cmd_o.base_next = 1'b1;
            state_d         = SRdAdr;
          end
        end
      end
      SWrChan: begin
        cmd_o.wr_chan = 1'b1;
        cmd_o.idx_inc = 1'b1;
        if (sts_i.idx_last_chan) begin
          state_d = SDone;
        end
      end
      SHuntAdr: state_d = SHuntDat;
      SHuntDat: begin
        cmd_o.hunt_take = 1'b1;
        if (sts_i.hunt_zero3) begin
          cmd_o.hunt_apply = sts_i.hunt_ok;
          state_d          = SDone;
        end else if (sts_i.idx_last_hunt) begin
          state_d = SDone;
        end else begin
          cmd_o.idx_inc = 1'b1;
          state_d       = SHuntAdr;
        end
      end
      SDone: begin
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = SIdle;
        end
      end
      default: state_d = SIdle;
    endcase
  end

  // Result beat stays valid until taken.
  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SClear;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

FILE: src/model_rail_bus_frame_transceiver.sv
// ----------------------------------------------------------------------------
// Model rail bus frame transceiver
// Each beat is sequenced over the datapath state by state: a rising edge
// shifts in a bit and, when a byte lands, writes it bit by bit; a falling edge
// checks the drive mark; a channel write or read walks the twelve channel
// bits; a tick may hunt bit position by bit position or search base frame by
// base frame. One beat is in work at a time, over bit-wide frame stores.
// After reset a clearing pass over all 1536 positions fills the stores first.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module model_rail_bus_frame_transceiver (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  mrbft_pkg::in_beat_t  in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output mrbft_pkg::out_beat_t out_data_o
);
  import mrbft_pkg::*;

  ctrl_cmd_t cmd;
  ctrl_sts_t sts;

  // Sequencer.
  mrbft_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // Stores and registers.
  mrbft_datapath u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_data_i  (in_data_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .out_data_o (out_data_o)
  );

  // An accepted beat keeps the block busy in the following cycle.
  `ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, in_valid_i && !in_stall_o, in_stall_o)
  // A result is never loaded over one that is still stalled.
  `ASSERT_IMPLY(a_no_overwrite, clk_i, rst_ni, cmd.out_load, !out_valid_o || !out_stall_i)
  // A result beat only becomes valid after a result load.
  `ASSERT_IMPLY(a_valid_from_load, clk_i, rst_ni, $rose(out_valid_o), $past(cmd.out_load))

endmodule

FILE: verif/tb_model_rail_bus_frame_transceiver.sv
// ----------------------------------------------------------------------------
// Model rail bus frame transceiver testbench
// Drives sampled bus bits, drive slots, channel reads and writes, ticks and
// sync drops through the beat interface. A built-in bus predictor computes the
// expected result beat for every accepted input beat. The checker compares
// results in order, field by field.
// ----------------------------------------------------------------------------
module tb_model_rail_bus_frame_transceiver;
  timeunit 1ns;
  timeprecision 1ps;
  import mrbft_pkg::*;

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_stall_o;
  in_beat_t  in_data_i;
  logic      out_valid_o;
  logic      out_stall_i;
  out_beat_t out_data_o;

  model_rail_bus_frame_transceiver u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  // Clock with a 20 ns period.
  initial clk_i = 1'b0;
  always #10 clk_i = ~clk_i;

  // Shadow copy of the transceiver state.
  logic [7:0]  rx_store [192];
  logic        tx_mark [FrameBits];
  logic        tx_level [FrameBits];
  logic [7:0]  shift_byte;
  int          bit_pos;
  logic [7:0]  frame_gen;
  logic [2:0]  phase;
  int          wait_pos;
  logic [7:0]  wait_gen;

  out_beat_t   pending_results [$];
  int          errors;
  int          func_count [8];
  int          sync_hits;
  bit          idle_on;
  int          out_burst;

  // Bus frame that the simulated master is sending.
  logic        bus_frame [FrameBits];
  int          bus_idx;
  bit          bus_bad_sync;

  function automatic logic rx_bit(int p);
    if (p >= FrameBits) return 1'b0;
    return rx_store[p >> 3][p & 7];
  endfunction

  function automatic logic [11:0] rx_word(int p);
    logic [11:0] w;
    for (int j = 0; j < ChanBits; j++) w[j] = rx_bit(p + j);
    return w;
  endfunction

  function automatic int chan_base(logic [6:0] ch);
    return (15 - int'(ch[3:0])) * BaseFrameBits + (7 - int'(ch[6:4])) * ChanBits;
  endfunction

  function automatic void note_wait();
    wait_pos = bit_pos & 11'h7FF;
    wait_gen = frame_gen;
  endfunction

  function automatic bit whole_frame_gone();
    logic [7:0] diff;
    diff = frame_gen - wait_gen;
    if (diff == 8'd0) return 1'b0;
    if (diff >= 8'd2) return 1'b1;
    return bit_pos >= wait_pos;
  endfunction

  // Sync state machine step.
  function automatic void step_sync();
    bit found;
    found = 1'b0;
    case (phase)
      PhHunt: begin
        if (bit_pos >= HuntMinBits) begin
          for (int i = 0; i < HuntLastIdx - 1; i++) begin
            if (!rx_bit(i) && !rx_bit(i + 1) && !rx_bit(i + 2)) begin
              if (bit_pos > i) begin
                bit_pos -= i;
                found = 1'b1;
              end
              break;
            end
          end
        end
        if (found) begin
          note_wait();
          phase = PhWait1;
        end
      end
      PhWait1: if (whole_frame_gone()) phase = PhFind;
      PhFind: begin
        for (int off = 0; off < FrameBits; off += BaseFrameBits) begin
          if ((rx_word(off) & SyncMask) == SyncZero) begin
            bit_pos = (bit_pos + FrameBits - off) % FrameBits;
            found = 1'b1;
            break;
          end
        end
        if (found) begin
          note_wait();
          phase = PhWait2;
        end else begin
          phase = PhHunt;
        end
      end
      PhWait2: if (whole_frame_gone()) phase = PhSync;
      PhSync: if ((rx_word(0) & SyncMask) != SyncZero) phase = PhHunt;
      default: phase = PhHunt;
    endcase
  endfunction

  // Expected result beat for one accepted input beat.
  function automatic out_beat_t bus_predict(in_beat_t b);
    out_beat_t   r;
    logic [11:0] w;
    int          p;
    r = '0;
    case (b.func)
      FuncRise: begin
        shift_byte = {b.data_bit, shift_byte[7:1]};
        bit_pos++;
        if ((bit_pos % 8) == 0 && bit_pos <= FrameBits) rx_store[bit_pos / 8 - 1] = shift_byte;
        if (bit_pos >= FrameBits) begin
          bit_pos = 0;
          frame_gen++;
        end
      end
      FuncFall: begin
        if (bit_pos < FrameBits && tx_mark[bit_pos]) begin
          tx_mark[bit_pos] = 1'b0;
          r.drive_enable = 1'b1;
          r.drive_value = tx_level[bit_pos];
        end
      end
      FuncRead: begin
        w = rx_word(chan_base(b.channel));
        r.channel_data = {w[10:9], w[7:6], w[4:3], w[1:0]};
      end
      FuncWrite: begin
        p = chan_base(b.channel);
        w = {1'b1, b.channel_value[7:6], 1'b1, b.channel_value[5:4], 1'b1,
             b.channel_value[3:2], 1'b1, b.channel_value[1:0]};
        for (int j = 0; j < ChanBits; j++) begin
          tx_level[p + j] = w[j];
          if (PayloadMask[j]) tx_mark[p + j] = 1'b1;
        end
      end
      FuncTick: step_sync();
      FuncDrop: begin
        bit_pos = 0;
        frame_gen = '0;
        phase = PhHunt;
      end
      default: ;
    endcase
    r.sync_phase_out = phase;
    return r;
  endfunction

  // Fill the next bus frame: every base frame opens with a sync word, only
  // base frame 0 with the one that matches. A bad frame has no match at all.
  function automatic void build_bus_frame();
    logic [11:0] w;
    logic [7:0]  v;
    for (int bf = 0; bf < 16; bf++) begin
      for (int c = 0; c < 8; c++) begin
        v = 8'($urandom);
        w = {1'b1, v[7:6], 1'b1, v[5:4], 1'b1, v[3:2], 1'b1, v[1:0]};
        if (c == 0) w = (bf == 0 && !bus_bad_sync) ? SyncZero : 12'h92C;
        for (int j = 0; j < ChanBits; j++) bus_frame[bf * BaseFrameBits + c * ChanBits + j] = w[j];
      end
    end
  endfunction

  function automatic logic next_bus_bit();
    logic v;
    if (bus_idx == 0) build_bus_frame();
    v = bus_frame[bus_idx];
    bus_idx = (bus_idx + 1) % FrameBits;
    return v;
  endfunction

  // Send one beat; called and returning at a falling edge with valid left high.
  task automatic send_beat(in_beat_t b);
    if (idle_on && $urandom_range(0, 9) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 15)) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= b;
    do @(posedge clk_i); while (in_stall_o);
    pending_results.push_back(bus_predict(b));
    func_count[b.func]++;
    if (phase == PhSync) sync_hits++;
    @(negedge clk_i);
  endtask

  task automatic send_op(logic [2:0] f, logic d, logic [6:0] ch, logic [7:0] v);
    in_beat_t b;
    b.func = f;
    b.data_bit = d;
    b.channel = ch;
    b.channel_value = v;
    send_beat(b);
  endtask

  // Hold off the sender until every expected result has come back.
  task automatic wait_results();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
  endtask

  // Reads after reset, a tick, writes, drive slots and rises, unused codes, sync drop.
  task automatic test_directed();
    send_op(FuncRead, 1'b0, 7'd0, 8'h00);
    send_op(FuncRead, 1'b1, 7'd127, 8'hFF);
    send_op(FuncRead, 1'b0, 7'd112, 8'h00);
    send_op(FuncTick, 1'b0, 7'd0, 8'h00);
    send_op(FuncWrite, 1'b0, 7'd127, 8'hA5);
    send_op(FuncWrite, 1'b0, 7'd0, 8'h00);
    send_op(FuncWrite, 1'b1, 7'd15, 8'hFF);
    send_op(FuncWrite, 1'b0, 7'd111, 8'h5A);
    for (int k = 0; k < 3; k++) begin
      send_op(FuncFall, 1'b0, 7'd0, 8'h00);
      send_op(FuncFall, 1'b0, 7'd0, 8'h00);
      send_op(FuncRise, 1'(k), 7'd0, 8'h00);
    end
    send_op(3'd6, 1'b1, 7'd127, 8'hFF);
    send_op(3'd7, 1'b0, 7'd0, 8'h00);
    send_op(FuncRise, 1'b0, 7'd0, 8'h00);
    send_op(FuncRise, 1'b1, 7'd0, 8'h00);
    send_op(FuncDrop, 1'b0, 7'd0, 8'h00);
    send_op(FuncFall, 1'b0, 7'd0, 8'h00);
    send_op(FuncRead, 1'b0, 7'd127, 8'h00);
  endtask

  // A third of a clean bus frame with regular ticks lets the sync hunt find
  // the base frame 0 mark and move on to the frame wait.
  task automatic test_sync_lock();
    bus_idx = 0;
    bus_bad_sync = 1'b0;
    for (int n = 0; n < FrameBits / 3; n++) begin
      send_op(FuncRise, next_bus_bit(), 7'd0, 8'h00);
      if (n % 8 == 7) send_op(FuncTick, 1'b0, 7'd0, 8'h00);
      if (n % 97 == 0) send_op(FuncRead, 1'b0, 7'($urandom_range(0, 127)), 8'h00);
      if (n % 131 == 0) send_op(FuncFall, 1'b0, 7'd0, 8'h00);
    end
  endtask

  // Mostly bus traffic with random content, plus noise on every code.
  task automatic test_random(int count);
    int   sel;
    logic d;
    for (int n = 0; n < count; n++) begin
      if (n == count / 2) wait_results();
      if (n == count - 200) idle_on = 1'b0;
      sel = $urandom_range(0, 99);
      d = ($urandom_range(0, 9) == 0) ? 1'($urandom) : next_bus_bit();
      if (sel < 40)      send_op(FuncRise, d, 7'($urandom), 8'($urandom));
      else if (sel < 55) send_op(FuncFall, 1'($urandom), 7'($urandom), 8'($urandom));
      else if (sel < 68) send_op(FuncRead, 1'($urandom), 7'($urandom), 8'($urandom));
      else if (sel < 80) send_op(FuncWrite, 1'($urandom), 7'($urandom), 8'($urandom));
      else if (sel < 93) send_op(FuncTick, 1'($urandom), 7'($urandom), 8'($urandom));
      else if (sel < 95) send_op(FuncDrop, 1'($urandom), 7'($urandom), 8'($urandom));
      else               send_op(3'($urandom_range(6, 7)), 1'($urandom), 7'($urandom),
                                 8'($urandom));
    end
  endtask

  // Receiver stall in random bursts.
  always @(negedge clk_i) begin
    if (!idle_on) begin
      out_stall_i <= 1'b0;
      out_burst <= 0;
    end else if (out_burst > 0) begin
      out_stall_i <= 1'b1;
      out_burst <= out_burst - 1;
    end else if ($urandom_range(0, 11) == 0) begin
      out_stall_i <= 1'b1;
      out_burst <= $urandom_range(0, 14);
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // Compare each result beat with the oldest expectation.
  always @(posedge clk_i) begin
    out_beat_t exp_beat;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result beat %p", $time, out_data_o);
      end else begin
        exp_beat = pending_results.pop_front();
        if (out_data_o.drive_enable !== exp_beat.drive_enable) begin
          errors++;
          $display("%0t: drive_enable expected %0d actual %0d", $time,
                   exp_beat.drive_enable, out_data_o.drive_enable);
        end
        if (out_data_o.drive_value !== exp_beat.drive_value) begin
          errors++;
          $display("%0t: drive_value expected %0d actual %0d", $time,
                   exp_beat.drive_value, out_data_o.drive_value);
        end
        if (out_data_o.channel_data !== exp_beat.channel_data) begin
          errors++;
          $display("%0t: channel_data expected %h actual %h", $time,
                   exp_beat.channel_data, out_data_o.channel_data);
        end
        if (out_data_o.sync_phase_out !== exp_beat.sync_phase_out) begin
          errors++;
          $display("%0t: sync_phase_out expected %0d actual %0d", $time,
                   exp_beat.sync_phase_out, out_data_o.sync_phase_out);
        end
      end
    end
  end

  // Watchdog.
  initial begin
    #300_000_000;
    $display("tb_model_rail_bus_frame_transceiver: done, errors");
    $finish;
  end

  // Main sequence.
  initial begin
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_data_i = '0;
    out_stall_i = 1'b0;
    out_burst = 0;
    errors = 0;
    sync_hits = 0;
    idle_on = 1'b1;
    bus_idx = 0;
    bus_bad_sync = 1'b0;
    foreach (func_count[k]) func_count[k] = 0;
    foreach (rx_store[k]) rx_store[k] = 8'hFF;
    foreach (tx_mark[k]) tx_mark[k] = 1'b0;
    foreach (tx_level[k]) tx_level[k] = 1'b0;
    shift_byte = '0;
    bit_pos = 0;
    frame_gen = '0;
    phase = PhHunt;
    wait_pos = 0;
    wait_gen = '0;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed();
    test_sync_lock();
    test_random(540);

    wait_results();
    repeat (600) @(negedge clk_i);
    $display("Covered %0d rises, %0d drive slots, %0d reads, %0d writes, %0d ticks,",
             func_count[0], func_count[1], func_count[2], func_count[3], func_count[4]);
    $display("%0d sync drops, %0d unused codes; %0d beats seen while locked.",
             func_count[5], func_count[6] + func_count[7], sync_hits);
    if (errors == 0) begin
      $display("tb_model_rail_bus_frame_transceiver: done, clean");
    end else begin
      $display("tb_model_rail_bus_frame_transceiver: done, errors");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+src
src/mrbft_pkg.sv
src/mrbft_datapath.sv
src/mrbft_ctrl.sv
src/model_rail_bus_frame_transceiver.sv
verif/tb_model_rail_bus_frame_transceiver.sv
